// ===== rtl/mieu_pkg.sv =====
// ----------------------------------------------------------------------------
// mieu_pkg
// shared types and opcode constants of the integer execute unit
// ----------------------------------------------------------------------------
package mieu_pkg;

	typedef struct packed {
		logic [5:0]  kind;
		logic [4:0]  source_reg_a;
		logic [4:0]  source_reg_b;
		logic [4:0]  dest_reg;
		logic [4:0]  shift_amount;
		logic [15:0] immediate;
		logic [25:0] jump_index;
		logic [31:0] instr_address;
	} in_word_t;

	typedef struct packed {
		logic        write_enable;
		logic [4:0]  write_reg;
		logic [31:0] write_value;
		logic        redirect;
		logic [31:0] branch_target;
		logic [1:0]  status;
	} out_word_t;

	localparam logic [5:0] K_SLL = 6'd0, K_SRL = 6'd1, K_SRA = 6'd2, K_SLLV = 6'd3,
		K_SRLV = 6'd4, K_SRAV = 6'd5, K_JR = 6'd6, K_JALR = 6'd7, K_MFHI = 6'd8,
		K_MTHI = 6'd9, K_MFLO = 6'd10, K_MTLO = 6'd11, K_MULT = 6'd12, K_MULTU = 6'd13,
		K_DIV = 6'd14, K_DIVU = 6'd15, K_ADD = 6'd16, K_ADDU = 6'd17, K_SUB = 6'd18,
		K_SUBU = 6'd19, K_AND = 6'd20, K_OR = 6'd21, K_XOR = 6'd22, K_NOR = 6'd23,
		K_SLT = 6'd24, K_SLTU = 6'd25, K_REGIMM = 6'd26, K_BEQ = 6'd27, K_BNE = 6'd28,
		K_BLEZ = 6'd29, K_BGTZ = 6'd30, K_ADDI = 6'd31, K_ADDIU = 6'd32, K_SLTI = 6'd33,
		K_SLTIU = 6'd34, K_ANDI = 6'd35, K_ORI = 6'd36, K_XORI = 6'd37, K_LUI = 6'd38,
		K_J = 6'd39, K_JAL = 6'd40;

	localparam logic [4:0] C_BLTZ = 5'd0, C_BGEZ = 5'd1, C_BLTZAL = 5'd16, C_BGEZAL = 5'd17;
	localparam logic [4:0] LINK_REG = 5'd31;

	localparam logic [1:0] ST_OK = 2'd0, ST_OVF = 2'd1, ST_ALIGN = 2'd2, ST_INVALID = 2'd3;

	// iterative multiply/divide request
	typedef struct packed {
		logic start;
		logic is_div;
		logic is_signed;
	} md_ctrl_t;

endpackage

// ===== rtl/mieu_muldiv.sv =====
// ----------------------------------------------------------------------------
// mieu_muldiv
// shift-add multiplier and restoring divider, one bit per cycle
// ----------------------------------------------------------------------------
module mieu_muldiv (
	input  logic              clk,
	input  logic              arst_n,
	input  mieu_pkg::md_ctrl_t ctrl,
	input  logic [31:0]       op_a,
	input  logic [31:0]       op_b,
	output logic              done,
	output logic [31:0]       res_hi,
	output logic [31:0]       res_lo
);
	import mieu_pkg::*;

	logic        busy_q, div_q, neg_q_q, neg_r_q;
	logic [5:0]  cnt_q;
	logic [31:0] acc_q, lo_q, b_q;
	logic [32:0] sum;
	logic [32:0] diff;
	logic [31:0] ma, mb;
	logic [31:0] fin_hi, fin_lo;
	logic [63:0] prod;

	assign ma = (ctrl.is_signed && op_a[31]) ? (32'd0 - op_a) : op_a;
	assign mb = (ctrl.is_signed && op_b[31]) ? (32'd0 - op_b) : op_b;

	// one add or one trial subtract per cycle
	assign sum  = {1'b0, acc_q} + (lo_q[0] ? {1'b0, b_q} : 33'd0);
	assign diff = {acc_q, lo_q[31]} - {1'b0, b_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= 6'd0;
		end else if (ctrl.start) begin
			busy_q <= 1'b1;
			cnt_q  <= 6'd0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 6'd1;
			if (cnt_q == 6'd31) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			div_q   <= ctrl.is_div;
			neg_q_q <= ctrl.is_signed && (op_a[31] ^ op_b[31]);
			neg_r_q <= ctrl.is_signed && op_a[31];
			acc_q   <= 32'd0;
			lo_q    <= ma;
			b_q     <= mb;
		end else if (busy_q) begin
			if (div_q) begin
				if (!diff[32]) begin
					acc_q <= diff[31:0];
					lo_q  <= {lo_q[30:0], 1'b1};
				end else begin
					acc_q <= {acc_q[30:0], lo_q[31]};
					lo_q  <= {lo_q[30:0], 1'b0};
				end
			end else begin
				acc_q <= sum[32:1];
				lo_q  <= {sum[0], lo_q[31:1]};
			end
		end
	end

	assign prod = {acc_q, lo_q};
	always_comb begin
		if (div_q) begin
			fin_lo = neg_q_q ? (32'd0 - lo_q) : lo_q;
			fin_hi = neg_r_q ? (32'd0 - acc_q) : acc_q;
		end else begin
			{fin_hi, fin_lo} = neg_q_q ? (64'd0 - prod) : prod;
		end
	end

	assign done   = busy_q && (cnt_q == 6'd31);
	assign res_hi = fin_hi;
	assign res_lo = fin_lo;
endmodule

// ===== rtl/mips_integer_execute_unit.sv =====
// ----------------------------------------------------------------------------
// mips_integer_execute_unit
// MIPS-I integer execute stage with register file and HI/LO
// ----------------------------------------------------------------------------
// One instruction at a time. Register operands are read from a 32-entry
// register file memory with registered read ports, so a plain instruction
// passes through read, execute and output states from accept to result, and the
// result register frees when the word is taken; the next word is accepted
// only after the unit is back in idle. Multiply and divide run in a
// bit-serial unit of 32 iterations, followed by a second execute pass that
// writes HI and LO (a divide by zero writes neither). After reset a clearing
// pass writes zero to all 32 registers before the first word is accepted.
module mips_integer_execute_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  mieu_pkg::in_word_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output mieu_pkg::out_word_t out_data
);
	import mieu_pkg::*;

	typedef enum logic [5:0] {
		S_CLEAR = 6'b000001,
		S_IDLE  = 6'b000010,
		S_READ  = 6'b000100,
		S_EXEC  = 6'b001000,
		S_MD    = 6'b010000,
		S_OUT   = 6'b100000
	} state_t;

	state_t      state_q;
	logic [4:0]  clr_q;
	in_word_t    ins_q;
	logic [31:0] rf_mem [32];
	logic [31:0] a_q, b_q, hi_q, lo_q;
	out_word_t   res_q;
	md_ctrl_t    md;
	logic        md_done;
	logic        md_ready_q;
	logic [31:0] md_hi, md_lo;
	logic        rf_we;
	logic [4:0]  rf_wa;
	logic [31:0] rf_wd;

	logic        we, taken;
	logic [4:0]  wreg;
	logic [31:0] wval, target, simm, zimm, opb, btarget, link, pc4, r;
	logic [1:0]  st;
	logic [32:0] addr;
	logic        is_sub, slt_s, slt_u;
	logic [4:0]  shamt;
	logic        hi_we, lo_we;
	logic [31:0] hi_d, lo_d;

	assign in_ready = (state_q == S_IDLE);

	mieu_muldiv u_md (
		.clk(clk), .arst_n(arst_n), .ctrl(md),
		.op_a(a_q), .op_b(b_q), .done(md_done), .res_hi(md_hi), .res_lo(md_lo)
	);

	// register file, registered dual read
	always_ff @(posedge clk) begin
		if (rf_we) rf_mem[rf_wa] <= rf_wd;
		a_q <= rf_mem[ins_q.source_reg_a];
		b_q <= rf_mem[ins_q.source_reg_b];
	end

	assign simm    = {{16{ins_q.immediate[15]}}, ins_q.immediate};
	assign zimm    = {16'd0, ins_q.immediate};
	assign btarget = ins_q.instr_address + 32'd4 + {simm[29:0], 2'b00};
	assign link    = ins_q.instr_address + 32'd8;
	assign pc4     = ins_q.instr_address + 32'd4;

	always_comb begin
		case (ins_q.kind)
			K_ADDI, K_ADDIU, K_SLTI, K_SLTIU: opb = simm;
			default: opb = b_q;
		endcase
	end
	assign is_sub = (ins_q.kind == K_SUB) || (ins_q.kind == K_SUBU)
		|| (ins_q.kind == K_SLT) || (ins_q.kind == K_SLTU)
		|| (ins_q.kind == K_SLTI) || (ins_q.kind == K_SLTIU);
	// one adder shared by add, subtract, immediate add and set-less-than
	assign addr  = {1'b0, a_q} + {1'b0, is_sub ? ~opb : opb} + {32'd0, is_sub};
	assign r     = addr[31:0];
	assign slt_u = !addr[32];
	assign slt_s = (a_q[31] ^ opb[31]) ? a_q[31] : r[31];
	assign shamt = (ins_q.kind == K_SLL || ins_q.kind == K_SRL || ins_q.kind == K_SRA)
		? ins_q.shift_amount : a_q[4:0];

	always_comb begin
		we = 1'b0; taken = 1'b0; wreg = ins_q.dest_reg; wval = 32'd0;
		target = 32'd0; st = ST_OK;
		hi_we = 1'b0; lo_we = 1'b0; hi_d = a_q; lo_d = a_q;
		case (ins_q.kind)
			K_SLL, K_SLLV: begin we = 1'b1; wval = b_q << shamt; end
			K_SRL, K_SRLV: begin we = 1'b1; wval = b_q >> shamt; end
			K_SRA, K_SRAV: begin we = 1'b1; wval = $signed(b_q) >>> shamt; end
			K_JR, K_JALR: begin
				if (a_q[1:0] != 2'b00) st = ST_ALIGN;
				else begin
					taken = 1'b1; target = a_q;
					if (ins_q.kind == K_JALR) begin we = 1'b1; wval = link; end
				end
			end
			K_MFHI: begin we = 1'b1; wval = hi_q; end
			K_MTHI: hi_we = 1'b1;
			K_MFLO: begin we = 1'b1; wval = lo_q; end
			K_MTLO: lo_we = 1'b1;
			K_MULT, K_MULTU: begin
				hi_we = 1'b1; lo_we = 1'b1; hi_d = md_hi; lo_d = md_lo;
			end
			K_DIV, K_DIVU: begin
				hi_we = (b_q != 32'd0); lo_we = hi_we; hi_d = md_hi; lo_d = md_lo;
			end
			K_ADD, K_SUB: begin
				// overflow when both addends agree in sign and the sum does not
				if ((a_q[31] == (opb[31] ^ is_sub)) && (r[31] != a_q[31])) st = ST_OVF;
				else begin we = 1'b1; wval = r; end
			end
			K_ADDU, K_SUBU: begin we = 1'b1; wval = r; end
			K_AND: begin we = 1'b1; wval = a_q & b_q; end
			K_OR:  begin we = 1'b1; wval = a_q | b_q; end
			K_XOR: begin we = 1'b1; wval = a_q ^ b_q; end
			K_NOR: begin we = 1'b1; wval = ~(a_q | b_q); end
			K_SLT: begin we = 1'b1; wval = {31'd0, slt_s}; end
			K_SLTU: begin we = 1'b1; wval = {31'd0, slt_u}; end
			K_REGIMM: begin
				case (ins_q.source_reg_b)
					C_BLTZ, C_BLTZAL, C_BGEZ, C_BGEZAL: begin
						if (a_q[31] ^ ins_q.source_reg_b[0]) begin
							taken = 1'b1; target = btarget;
							if (ins_q.source_reg_b[4]) begin
								we = 1'b1; wreg = LINK_REG; wval = link;
							end
						end
					end
					default: st = ST_INVALID;
				endcase
			end
			K_BEQ:  if (a_q == b_q) begin taken = 1'b1; target = btarget; end
			K_BNE:  if (a_q != b_q) begin taken = 1'b1; target = btarget; end
			K_BLEZ: if (a_q[31] || a_q == 32'd0) begin taken = 1'b1; target = btarget; end
			K_BGTZ: if (!a_q[31] && a_q != 32'd0) begin taken = 1'b1; target = btarget; end
			K_ADDI: begin
				wreg = ins_q.source_reg_b;
				if ((a_q[31] == simm[31]) && (r[31] != a_q[31])) st = ST_OVF;
				else begin we = 1'b1; wval = r; end
			end
			K_ADDIU: begin we = 1'b1; wreg = ins_q.source_reg_b; wval = r; end
			K_SLTI:  begin we = 1'b1; wreg = ins_q.source_reg_b; wval = {31'd0, slt_s}; end
			K_SLTIU: begin we = 1'b1; wreg = ins_q.source_reg_b; wval = {31'd0, slt_u}; end
			K_ANDI: begin we = 1'b1; wreg = ins_q.source_reg_b; wval = a_q & zimm; end
			K_ORI:  begin we = 1'b1; wreg = ins_q.source_reg_b; wval = a_q | zimm; end
			K_XORI: begin we = 1'b1; wreg = ins_q.source_reg_b; wval = a_q ^ zimm; end
			K_LUI:  begin we = 1'b1; wreg = ins_q.source_reg_b; wval = {ins_q.immediate, 16'd0}; end
			K_J, K_JAL: begin
				taken = 1'b1;
				target = {pc4[31:28], ins_q.jump_index, 2'b00};
				if (ins_q.kind == K_JAL) begin we = 1'b1; wreg = LINK_REG; wval = link; end
			end
			default: st = ST_INVALID;
		endcase
		if (wreg == 5'd0) we = 1'b0;
		if (!we) begin wreg = 5'd0; wval = 32'd0; end
	end

	// second pass through exec after the serial unit only commits HI/LO
	assign md.start     = (state_q == S_EXEC) && !md_ready_q && (ins_q.kind == K_MULT
		|| ins_q.kind == K_MULTU || ins_q.kind == K_DIV || ins_q.kind == K_DIVU);
	assign md.is_div    = ins_q.kind[1];
	assign md.is_signed = !ins_q.kind[0];

	assign rf_we = (state_q == S_CLEAR) || (state_q == S_EXEC && !md.start && we);
	assign rf_wa = (state_q == S_CLEAR) ? clr_q : wreg;
	assign rf_wd = (state_q == S_CLEAR) ? 32'd0 : wval;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= 5'd0;
			hi_q    <= 32'd0;
			lo_q    <= 32'd0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 5'd1;
					if (clr_q == 5'd31) state_q <= S_IDLE;
				end
				S_IDLE: if (in_valid) state_q <= S_READ;
				S_READ: state_q <= S_EXEC;
				S_EXEC: begin
					if (md.start) state_q <= S_MD;
					else begin
						if (hi_we) hi_q <= hi_d;
						if (lo_we) lo_q <= lo_d;
						state_q <= S_OUT;
					end
				end
				S_MD: if (md_done) state_q <= S_EXEC;
				S_OUT: if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// after the serial unit finishes the word re-enters exec with results ready
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) md_ready_q <= 1'b0;
		else md_ready_q <= (state_q == S_MD) && md_done;
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) ins_q <= in_data;
		if (state_q == S_EXEC) res_q <= '{we, wreg, wval, taken, target, st};
	end

	assign out_valid = (state_q == S_OUT);
	assign out_data  = res_q;
endmodule

// ===== bench/execute_checker.sv =====
// ----------------------------------------------------------------------------
// execute_checker
// predicts each instruction's write, branch and status and compares results
// ----------------------------------------------------------------------------
module execute_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  mieu_pkg::in_word_t  in_data,
	input  logic                out_valid,
	input  logic                out_ready,
	input  mieu_pkg::out_word_t out_data,
	output int                  fail_count,
	output int                  pending_count
);
	import mieu_pkg::*;

	logic [31:0] gpr [32];
	logic [31:0] hi_val, lo_val;
	out_word_t   expected_q [$];

	function automatic logic [31:0] shift_right_arith(logic [31:0] v, logic [4:0] s);
		return $unsigned($signed(v) >>> s);
	endfunction

	task automatic execute_instr(input in_word_t w, output out_word_t r);
		logic [31:0] a, b, simm, btgt, link, sum;
		logic [63:0] prod;
		logic        we, taken;
		logic [4:0]  wreg;
		logic [31:0] wval, tgt;
		logic [1:0]  st;
		logic        cond;
		a = gpr[w.source_reg_a];
		b = gpr[w.source_reg_b];
		simm = {{16{w.immediate[15]}}, w.immediate};
		btgt = w.instr_address + 32'd4 + (simm << 2);
		link = w.instr_address + 32'd8;
		we = 0; taken = 0; wreg = 0; wval = 0; tgt = 0; st = ST_OK;
		case (w.kind)
			K_SLL: begin we = 1; wreg = w.dest_reg; wval = b << w.shift_amount; end
			K_SRL: begin we = 1; wreg = w.dest_reg; wval = b >> w.shift_amount; end
			K_SRA: begin
				we = 1; wreg = w.dest_reg; wval = shift_right_arith(b, w.shift_amount);
			end
			K_SLLV: begin we = 1; wreg = w.dest_reg; wval = b << a[4:0]; end
			K_SRLV: begin we = 1; wreg = w.dest_reg; wval = b >> a[4:0]; end
			K_SRAV: begin we = 1; wreg = w.dest_reg; wval = shift_right_arith(b, a[4:0]); end
			K_JR, K_JALR: begin
				if (a[1:0] != 0) st = ST_ALIGN;
				else begin
					taken = 1; tgt = a;
					if (w.kind == K_JALR) begin we = 1; wreg = w.dest_reg; wval = link; end
				end
			end
			K_MFHI: begin we = 1; wreg = w.dest_reg; wval = hi_val; end
			K_MTHI: hi_val = a;
			K_MFLO: begin we = 1; wreg = w.dest_reg; wval = lo_val; end
			K_MTLO: lo_val = a;
			K_MULT: begin
				prod = $unsigned(64'($signed(a)) * 64'($signed(b)));
				hi_val = prod[63:32]; lo_val = prod[31:0];
			end
			K_MULTU: begin
				prod = {32'd0, a} * {32'd0, b};
				hi_val = prod[63:32]; lo_val = prod[31:0];
			end
			K_DIV: begin
				if (b != 0) begin
					// most negative by -1 wraps to itself with zero remainder
					if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) begin
						lo_val = a; hi_val = 0;
					end else begin
						lo_val = $unsigned($signed(a) / $signed(b));
						hi_val = $unsigned($signed(a) % $signed(b));
					end
				end
			end
			K_DIVU: if (b != 0) begin lo_val = a / b; hi_val = a % b; end
			K_ADD: begin
				sum = a + b;
				if (((a ^ sum) & (b ^ sum)) >> 31) st = ST_OVF;
				else begin we = 1; wreg = w.dest_reg; wval = sum; end
			end
			K_ADDU: begin we = 1; wreg = w.dest_reg; wval = a + b; end
			K_SUB: begin
				sum = a - b;
				if (((a ^ b) & (a ^ sum)) >> 31) st = ST_OVF;
				else begin we = 1; wreg = w.dest_reg; wval = sum; end
			end
			K_SUBU: begin we = 1; wreg = w.dest_reg; wval = a - b; end
			K_AND: begin we = 1; wreg = w.dest_reg; wval = a & b; end
			K_OR: begin we = 1; wreg = w.dest_reg; wval = a | b; end
			K_XOR: begin we = 1; wreg = w.dest_reg; wval = a ^ b; end
			K_NOR: begin we = 1; wreg = w.dest_reg; wval = ~(a | b); end
			K_SLT: begin we = 1; wreg = w.dest_reg; wval = {31'd0, $signed(a) < $signed(b)}; end
			K_SLTU: begin we = 1; wreg = w.dest_reg; wval = {31'd0, a < b}; end
			K_REGIMM: begin
				if (w.source_reg_b inside {C_BLTZ, C_BLTZAL, C_BGEZ, C_BGEZAL}) begin
					cond = (w.source_reg_b == C_BLTZ || w.source_reg_b == C_BLTZAL)
						? a[31] : !a[31];
					if (cond) begin
						taken = 1; tgt = btgt;
						if (w.source_reg_b[4]) begin we = 1; wreg = LINK_REG; wval = link; end
					end
				end else st = ST_INVALID;
			end
			K_BEQ: if (a == b) begin taken = 1; tgt = btgt; end
			K_BNE: if (a != b) begin taken = 1; tgt = btgt; end
			K_BLEZ: if (a[31] || a == 0) begin taken = 1; tgt = btgt; end
			K_BGTZ: if (!a[31] && a != 0) begin taken = 1; tgt = btgt; end
			K_ADDI: begin
				sum = a + simm;
				if (((a ^ sum) & (simm ^ sum)) >> 31) st = ST_OVF;
				else begin we = 1; wreg = w.source_reg_b; wval = sum; end
			end
			K_ADDIU: begin we = 1; wreg = w.source_reg_b; wval = a + simm; end
			K_SLTI: begin
				we = 1; wreg = w.source_reg_b; wval = {31'd0, $signed(a) < $signed(simm)};
			end
			K_SLTIU: begin we = 1; wreg = w.source_reg_b; wval = {31'd0, a < simm}; end
			K_ANDI: begin we = 1; wreg = w.source_reg_b; wval = a & {16'd0, w.immediate}; end
			K_ORI: begin we = 1; wreg = w.source_reg_b; wval = a | {16'd0, w.immediate}; end
			K_XORI: begin we = 1; wreg = w.source_reg_b; wval = a ^ {16'd0, w.immediate}; end
			K_LUI: begin we = 1; wreg = w.source_reg_b; wval = {w.immediate, 16'd0}; end
			K_J, K_JAL: begin
				taken = 1;
				tgt = ((w.instr_address + 32'd4) & 32'hF000_0000) | {4'd0, w.jump_index, 2'b00};
				if (w.kind == K_JAL) begin we = 1; wreg = LINK_REG; wval = link; end
			end
			default: st = ST_INVALID;
		endcase
		if (we && wreg == 0) we = 0;
		if (we) gpr[wreg] = wval;
		else begin wreg = 0; wval = 0; end
		if (!taken) tgt = 0;
		r = '{write_enable: we, write_reg: wreg, write_value: wval,
			redirect: taken, branch_target: tgt, status: st};
	endtask

	assign pending_count = expected_q.size();

	always @(posedge clk or negedge arst_n) begin
		out_word_t e;
		if (!arst_n) begin
			for (int i = 0; i < 32; i++) gpr[i] = 0;
			hi_val = 0; lo_val = 0;
			expected_q.delete();
			fail_count = 0;
		end else begin
			if (in_valid && in_ready) begin
				execute_instr(in_data, e);
				expected_q.push_back(e);
			end
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					$error("unexpected result word %h", out_data);
					fail_count++;
				end else begin
					e = expected_q.pop_front();
					if (out_data.write_enable !== e.write_enable) begin
						$error("write_enable exp %h got %h", e.write_enable, out_data.write_enable);
						fail_count++;
					end
					if (out_data.write_reg !== e.write_reg) begin
						$error("write_reg exp %h got %h", e.write_reg, out_data.write_reg);
						fail_count++;
					end
					if (out_data.write_value !== e.write_value) begin
						$error("write_value exp %h got %h", e.write_value, out_data.write_value);
						fail_count++;
					end
					if (out_data.redirect !== e.redirect) begin
						$error("redirect exp %h got %h", e.redirect, out_data.redirect);
						fail_count++;
					end
					if (out_data.branch_target !== e.branch_target) begin
						$error("branch_target exp %h got %h", e.branch_target,
							out_data.branch_target);
						fail_count++;
					end
					if (out_data.status !== e.status) begin
						$error("status exp %h got %h", e.status, out_data.status);
						fail_count++;
					end
				end
			end
		end
	end

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// directed and random instruction streams with random gaps on both channels
// ----------------------------------------------------------------------------
module testbench;
	import mieu_pkg::*;

	localparam int STALL_LIMIT = 2000;

	logic      clk, arst_n;
	logic      in_valid, in_ready, out_valid, out_ready;
	in_word_t  in_data;
	out_word_t out_data;
	int        fail_count, pending_count;
	int        idle_cycles = 0;

	mips_integer_execute_unit dut (.*);

	execute_checker checker_i (.*);

	always begin
		clk = 1'b0; #10;
		clk = 1'b1; #10;
	end

	// stall and timeout watch on accepts
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
	end

	always @(posedge clk) begin
		if (idle_cycles >= STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// receiver: random wait before each word
	initial begin
		int gap;
		out_ready = 0;
		@(posedge arst_n);
		forever begin
			gap = $urandom_range(0, 4);
			if (gap != 0) begin
				out_ready <= 0;
				repeat (gap) @(negedge clk);
			end
			out_ready <= 1;
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
		end
	end

	function automatic logic [31:0] rand_value();
		case ($urandom_range(0, 6))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return 32'h8000_0000;
			3: return 32'h7FFF_FFFF;
			4: return 32'($urandom_range(0, 15));
			default: return $urandom;
		endcase
	endfunction

	// starts at the falling edge after the previous accept, returns at the accepting edge
	task automatic send_word(input in_word_t w, input bit use_gap);
		int gap;
		gap = use_gap ? $urandom_range(0, 4) : 0;
		@(negedge clk);
		if (gap != 0) begin
			in_valid <= 0;
			repeat (gap) @(negedge clk);
		end
		in_data <= w;
		in_valid <= 1;
		do @(posedge clk); while (!in_ready);
	endtask

	function automatic in_word_t make_word(logic [5:0] k, logic [4:0] ra, logic [4:0] rb,
			logic [4:0] rd, logic [15:0] imm);
		in_word_t w;
		w.kind = k; w.source_reg_a = ra; w.source_reg_b = rb; w.dest_reg = rd;
		w.shift_amount = 5'($urandom); w.immediate = imm; w.jump_index = 26'($urandom);
		w.instr_address = $urandom;
		return w;
	endfunction

	// load a register through lui and ori
	task automatic load_reg(input logic [4:0] r, input logic [31:0] v, input bit g);
		send_word(make_word(K_LUI, 5'd0, r, 5'd0, v[31:16]), g);
		send_word(make_word(K_ORI, r, r, 5'd0, v[15:0]), g);
	endtask

	initial begin
		in_word_t w;
		arst_n = 0;
		in_valid = 0;
		in_data = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: extremes, overflow, misalignment, special divides, links
		load_reg(5'd1, 32'h7FFF_FFFF, 1'b0);
		load_reg(5'd2, 32'h8000_0000, 1'b0);
		load_reg(5'd3, 32'hFFFF_FFFF, 1'b0);
		send_word(make_word(K_ADD, 5'd1, 5'd1, 5'd4, 16'h0000), 1'b0);
		send_word(make_word(K_SUB, 5'd2, 5'd1, 5'd4, 16'h0000), 1'b0);
		send_word(make_word(K_ADDI, 5'd1, 5'd5, 5'd0, 16'h0001), 1'b0);
		send_word(make_word(K_DIV, 5'd2, 5'd3, 5'd0, 16'h0000), 1'b0);
		send_word(make_word(K_MFLO, 5'd0, 5'd0, 5'd6, 16'h0000), 1'b0);
		send_word(make_word(K_MFHI, 5'd0, 5'd0, 5'd7, 16'h0000), 1'b0);
		send_word(make_word(K_DIVU, 5'd1, 5'd0, 5'd0, 16'h0000), 1'b0);
		send_word(make_word(K_MFHI, 5'd0, 5'd0, 5'd8, 16'h0000), 1'b0);
		send_word(make_word(K_JR, 5'd3, 5'd0, 5'd0, 16'h0000), 1'b0);
		send_word(make_word(K_JALR, 5'd0, 5'd0, 5'd9, 16'h0000), 1'b0);
		send_word(make_word(K_REGIMM, 5'd2, C_BLTZAL, 5'd0, 16'h8000), 1'b0);
		send_word(make_word(K_REGIMM, 5'd2, C_BGEZAL, 5'd0, 16'h7FFF), 1'b0);
		send_word(make_word(K_REGIMM, 5'd2, 5'd9, 5'd0, 16'h0000), 1'b0);
		send_word(make_word(K_SLL, 5'd0, 5'd3, 5'd0, 16'h0000), 1'b0);
		send_word(make_word(6'd63, 5'd0, 5'd0, 5'd0, 16'h0000), 1'b0);
		send_word(make_word(K_JAL, 5'd0, 5'd0, 5'd0, 16'h0000), 1'b0);
		send_word(make_word(K_MULT, 5'd2, 5'd3, 5'd0, 16'h0000), 1'b0);

		// random instruction mix
		for (int n = 0; n < 1650; n++) begin
			if ($urandom_range(0, 9) == 0) begin
				load_reg(5'($urandom), rand_value(), 1'b1);
				n++;
				continue;
			end
			w.kind = ($urandom_range(0, 19) == 0) ? 6'($urandom_range(41, 63))
				: 6'($urandom_range(0, 40));
			w.source_reg_a = $urandom_range(0, 7) == 0 ? 5'd0 : 5'($urandom_range(0, 31));
			w.source_reg_b = (w.kind == K_REGIMM && $urandom_range(0, 3) != 0)
				? ($urandom_range(0, 1) ? 5'($urandom_range(0, 1))
					: 5'($urandom_range(16, 17)))
				: 5'($urandom);
			w.dest_reg = 5'($urandom);
			w.shift_amount = 5'($urandom);
			w.immediate = 16'($urandom);
			w.jump_index = 26'($urandom);
			w.instr_address = $urandom;
			send_word(w, 1'b1);
		end
		@(negedge clk);
		in_valid <= 0;

		while (pending_count != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (fail_count == 0) $display("CHECK OK");
		else $display("CHECK FAILED");
		$finish;
	end

endmodule
